### sv/ffid_pkg.sv
// Shared types and constants of the free-fall and impact fall detector.
`default_nettype none

package ffid_pkg;

   // Widths fixed by the sample and register formats.
   localparam int ACCEL_BITS     = 16;
   localparam int ELAPSED_BITS   = 32;
   localparam int CFG_TIME_BITS  = 40;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 40;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_LIMIT   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_LIMIT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FF_MIN      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FF_REJECT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALL_WINDOW = 3'd4;

   // Register values after reset.
   localparam logic [ACCEL_BITS-1:0]    LOW_LIMIT_RST   = 16'd96;
   localparam logic [ACCEL_BITS-1:0]    HIGH_LIMIT_RST  = 16'd9600;
   localparam logic [CFG_TIME_BITS-1:0] FF_MIN_RST      = 40'd800000000;
   localparam logic [CFG_TIME_BITS-1:0] FF_REJECT_RST   = 40'd150000000;
   localparam logic [CFG_TIME_BITS-1:0] FALL_WINDOW_RST = 40'd32000000000;

   // Reported detection phase.
   typedef enum logic [1:0] {
      PHASE_INIT     = 2'd0,
      PHASE_FREEFALL = 2'd1,
      PHASE_IMPACT   = 2'd2
   } phase_type;

   // Configuration register set.
   typedef struct packed {
      logic [ACCEL_BITS-1:0]    low_limit;
      logic [ACCEL_BITS-1:0]    high_limit;
      logic [CFG_TIME_BITS-1:0] ff_min;
      logic [CFG_TIME_BITS-1:0] ff_reject;
      logic [CFG_TIME_BITS-1:0] fall_window;
   } cfg_type;

   // Detector flags carried from one sample to the next.
   typedef struct packed {
      logic      ff_timing;
      logic      freefall_seen;
      logic      impact_seen;
      phase_type phase;
   } det_state_type;

endpackage

`default_nettype wire

### sv/freefall_impact_fall_detector.sv
// Top level of the free-fall and impact fall detector.
//
// Use: each beat on the req_ channel carries one accelerometer sample
// (instantaneous magnitude, windowed average, nanoseconds since the last
// sample). Each sample yields exactly one beat on the rsp_ channel with the
// detection phase after that sample and a one-sample fall flag.
// An accepted sample's result is registered in the output register, or in
// the skid stage while a stalled result holds it. One sample per cycle is
// taken while req_stall is low; the detector state and both timers update
// in the cycle the sample is taken. The output register is backed by a
// one-entry skid stage, so one more sample is accepted while a result waits
// on a stalled receiver; req_stall rises only while the skid stage is full.
// Registers are written through the csr_ channel, which is always ready;
// write them only while the detector is idle. An index beyond the register
// list is ignored.
// Reset (synchronous) clears the detector state, both timers and both
// result stages, and loads the register defaults.
`default_nettype none

module freefall_impact_fall_detector
   import ffid_pkg::*;
#(
   parameter int TIMER_BITS = 40
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Sample channel.
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [ACCEL_BITS-1:0]     req_inst_accel,
   input  wire logic [ACCEL_BITS-1:0]     req_window_avg,
   input  wire logic [ELAPSED_BITS-1:0]   req_elapsed_ns,
   // Result channel.
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_detect_phase,
   output logic                           rsp_fall_detected,
   // Register write channel.
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type               cfg_ff;
   det_state_type         state_ff;
   det_state_type         state_in;
   logic [TIMER_BITS-1:0] inner_ff;
   logic [TIMER_BITS-1:0] inner_in;
   logic [TIMER_BITS-1:0] outer_ff;
   logic [TIMER_BITS-1:0] outer_in;
   logic                  fall_in;
   logic                  req_take;
   logic                  rsp_take;
   logic                  out_valid_ff;
   logic [1:0]            out_phase_ff;
   logic                  out_fall_ff;
   logic                  skid_valid_ff;
   logic [1:0]            skid_phase_ff;
   logic                  skid_fall_ff;

   assign csr_ready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit   <= LOW_LIMIT_RST;
         cfg_ff.high_limit  <= HIGH_LIMIT_RST;
         cfg_ff.ff_min      <= FF_MIN_RST;
         cfg_ff.ff_reject   <= FF_REJECT_RST;
         cfg_ff.fall_window <= FALL_WINDOW_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_LIMIT:   cfg_ff.low_limit   <= csr_wdata[ACCEL_BITS-1:0];
            CSR_HIGH_LIMIT:  cfg_ff.high_limit  <= csr_wdata[ACCEL_BITS-1:0];
            CSR_FF_MIN:      cfg_ff.ff_min      <= csr_wdata[CFG_TIME_BITS-1:0];
            CSR_FF_REJECT:   cfg_ff.ff_reject   <= csr_wdata[CFG_TIME_BITS-1:0];
            CSR_FALL_WINDOW: cfg_ff.fall_window <= csr_wdata[CFG_TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Per-sample detector logic.
   ffid_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .cfg        (cfg_ff),
      .state_q    (state_ff),
      .inner_q    (inner_ff),
      .outer_q    (outer_ff),
      .inst_accel (req_inst_accel),
      .window_avg (req_window_avg),
      .elapsed_ns (req_elapsed_ns),
      .state_d    (state_in),
      .inner_d    (inner_in),
      .outer_d    (outer_in),
      .fall       (fall_in)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // Detector state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{ff_timing: 1'b0, freefall_seen: 1'b0, impact_seen: 1'b0,
                        phase: PHASE_INIT};
         inner_ff <= '0;
         outer_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
      end
   end

   // Output register with a one-entry skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result payloads follow the same moves as the valid bits.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_phase_ff <= skid_phase_ff;
            out_fall_ff  <= skid_fall_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_phase_ff <= state_in.phase;
            skid_fall_ff  <= fall_in;
         end else begin
            out_phase_ff <= state_in.phase;
            out_fall_ff  <= fall_in;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_detect_phase  = out_phase_ff;
   assign rsp_fall_detected = out_fall_ff;

endmodule

`default_nettype wire

### sv/ffid_step.sv
// Next-state and result logic of the fall detector for one sample.
`default_nettype none

module ffid_step
   import ffid_pkg::*;
#(
   parameter int TIMER_BITS = 40
) (
   input  wire cfg_type                  cfg,
   input  wire det_state_type            state_q,
   input  wire logic [TIMER_BITS-1:0]    inner_q,
   input  wire logic [TIMER_BITS-1:0]    outer_q,
   input  wire logic [ACCEL_BITS-1:0]    inst_accel,
   input  wire logic [ACCEL_BITS-1:0]    window_avg,
   input  wire logic [ELAPSED_BITS-1:0]  elapsed_ns,
   output det_state_type                 state_d,
   output logic [TIMER_BITS-1:0]         inner_d,
   output logic [TIMER_BITS-1:0]         outer_d,
   output logic                          fall
);

   // Comparisons are done at the wider of the timer and register widths.
   localparam int CMP_BITS = (TIMER_BITS > CFG_TIME_BITS) ? TIMER_BITS : CFG_TIME_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   logic                  below_low;
   logic                  impact;
   logic [TIMER_BITS-1:0] inner_base;
   logic [TIMER_BITS-1:0] outer_base;
   logic [TIMER_BITS:0]   inner_sum;
   logic [TIMER_BITS:0]   outer_sum;
   logic [TIMER_BITS-1:0] inner_sat;
   logic [TIMER_BITS-1:0] outer_sat;
   logic                  window_over;
   det_state_type         mid;

   // Sample classification against the limits.
   assign below_low = inst_accel < cfg.low_limit;
   // The pending impact is set and consumed by the same sample, so it never
   // outlives a step and needs no register of its own.
   assign impact    = !below_low && state_q.freefall_seen && (inst_accel > cfg.high_limit);

   // A low sample restarts both timers before the elapsed time is added.
   assign inner_base = below_low ? '0 : inner_q;
   assign outer_base = below_low ? '0 : outer_q;

   // Saturating timer adds.
   assign inner_sum = {1'b0, inner_base} + (TIMER_BITS+1)'(elapsed_ns);
   assign outer_sum = {1'b0, outer_base} + (TIMER_BITS+1)'(elapsed_ns);
   assign inner_sat = inner_sum[TIMER_BITS] ? TIMER_MAX : inner_sum[TIMER_BITS-1:0];
   assign outer_sat = outer_sum[TIMER_BITS] ? TIMER_MAX : outer_sum[TIMER_BITS-1:0];

   assign window_over = CMP_BITS'(outer_sat) > CMP_BITS'(cfg.fall_window);

   // Free-fall timing and phase updates before the window check.
   always_comb begin
      mid = state_q;
      if (below_low) begin
         mid.ff_timing = !state_q.ff_timing;
      end
      if (mid.ff_timing) begin
         if ((CMP_BITS'(inner_base) > CMP_BITS'(cfg.ff_min)) &&
             (window_avg < cfg.low_limit)) begin
            mid.phase         = PHASE_FREEFALL;
            mid.freefall_seen = 1'b1;
            mid.ff_timing     = 1'b0;
         end else if ((CMP_BITS'(inner_base) < CMP_BITS'(cfg.ff_reject)) &&
                      (window_avg > cfg.low_limit)) begin
            mid.ff_timing = 1'b0;
         end
      end
      if (impact) begin
         mid.phase       = PHASE_IMPACT;
         mid.impact_seen = 1'b1;
      end
   end

   // Window check: report a fall or expire the window.
   always_comb begin
      state_d = mid;
      outer_d = outer_sat;
      fall    = 1'b0;
      if (!window_over && mid.freefall_seen && mid.impact_seen) begin
         fall              = 1'b1;
         state_d.phase     = PHASE_INIT;
         state_d.ff_timing = 1'b0;
      end else if (window_over) begin
         state_d.phase         = PHASE_INIT;
         state_d.freefall_seen = 1'b0;
         state_d.impact_seen   = 1'b0;
         state_d.ff_timing     = 1'b0;
         outer_d               = '0;
      end
   end

   assign inner_d = inner_sat;

endmodule

`default_nettype wire

### sv/ffid_checker.sv
// Port-level checks of the fall detector and their binding to the top level.
`default_nettype none

module ffid_checker
   import ffid_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_stall,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_stall,
   input wire logic [1:0]                rsp_detect_phase,
   input wire logic                      rsp_fall_detected
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_detect_phase) &&
                                 $stable(rsp_fall_detected))
      else $error("stalled result beat changed");

   // A confirmed fall always reports the initial phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fall_detected |-> rsp_detect_phase == PHASE_INIT)
      else $error("fall reported with a nonzero phase");

   // The phase code never takes the unused value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_detect_phase != 2'd3)
      else $error("unused phase code on result");

   // Reset empties the result side.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // No result appears without a sample behind it.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result beat without an accepted sample");

endmodule

bind freefall_impact_fall_detector ffid_checker u_ffid_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_detect_phase  (rsp_detect_phase),
   .rsp_fall_detected (rsp_fall_detected)
);

`default_nettype wire
